### rtl/core/tbdar_pkg.sv
// Package for the two-switch debounce block: phase codes, widths and the
// per-switch state record shared by the lane, merge and top-level modules.
// Depends on nothing.
`default_nettype none

package tbdar_pkg;

  localparam int unsigned CountW = 16;
  localparam int unsigned PhaseW = 2;
  localparam int unsigned CfgIdxW = 1;

  localparam logic [PhaseW-1:0] PH_RELEASED   = 2'd0;
  localparam logic [PhaseW-1:0] PH_SETTLE_ON  = 2'd1;
  localparam logic [PhaseW-1:0] PH_HELD       = 2'd2;
  localparam logic [PhaseW-1:0] PH_SETTLE_OFF = 2'd3;

  localparam logic [CfgIdxW-1:0] CFG_SETTLE = 1'd0;
  localparam logic [CfgIdxW-1:0] CFG_REPEAT = 1'd1;

  localparam logic [CountW-1:0] SETTLE_RESET = 16'd80;
  localparam logic [CountW-1:0] REPEAT_RESET = 16'd500;

  typedef struct packed {
    logic [PhaseW-1:0] phase;
    logic [CountW-1:0] count;
  } sw_state_t;

  typedef struct packed {
    sw_state_t st;
    logic      event_hit;
  } lane_res_t;

endpackage

`default_nettype wire

### rtl/core/tbdar_lane.sv
// One switch lane: steps the four-phase debounce machine for one tick.
// Uses tbdar_pkg for phase codes and the state record.
`default_nettype none

module tbdar_lane
  import tbdar_pkg::*;
(
  input  sw_state_t         cur_i,
  input  logic              pressed_i,
  input  logic [CountW-1:0] settle_ticks_i,
  input  logic [CountW-1:0] repeat_ticks_i,
  output lane_res_t         res_o
);

  logic [CountW-1:0] dec;

  assign dec = cur_i.count - CountW'(1);

  always_comb begin
    res_o.st        = cur_i;
    res_o.event_hit = 1'b0;
    unique case (cur_i.phase)
      PH_RELEASED: begin
        if (pressed_i) begin
          res_o.st.phase = PH_SETTLE_ON;
          res_o.st.count = settle_ticks_i;
        end
      end
      PH_SETTLE_ON: begin
        res_o.st.count = dec;
        if (dec == '0) begin
          res_o.event_hit = 1'b1;
          res_o.st.phase  = PH_HELD;
          res_o.st.count  = repeat_ticks_i;
        end
      end
      PH_HELD: begin
        if (!pressed_i) begin
          res_o.st.phase = PH_SETTLE_OFF;
          res_o.st.count = settle_ticks_i;
        end else begin
          res_o.st.count = dec;
          if (dec == '0) begin
            res_o.event_hit = 1'b1;
            res_o.st.count  = repeat_ticks_i;
          end
        end
      end
      default: begin
        res_o.st.count = dec;
        if (dec == '0) begin
          res_o.st.phase = PH_RELEASED;
        end
      end
    endcase
  end

endmodule

`default_nettype wire

### rtl/core/tbdar_merge.sv
// Merging stage: a switch still settling its press takes over the other
// switch's state and reports an event when the other switch fires.
// Uses tbdar_pkg for phase codes and the lane result record.
`default_nettype none

module tbdar_merge
  import tbdar_pkg::*;
(
  input  lane_res_t first_i,
  input  lane_res_t second_i,
  output lane_res_t first_o,
  output lane_res_t second_o
);

  lane_res_t first_m;

  always_comb begin
    first_m = first_i;
    if (first_i.st.phase == PH_SETTLE_ON && second_i.event_hit) begin
      first_m.event_hit = 1'b1;
      first_m.st        = second_i.st;
    end
    second_o = second_i;
    if (second_i.st.phase == PH_SETTLE_ON && first_m.event_hit) begin
      second_o.event_hit = 1'b1;
      second_o.st        = first_m.st;
    end
    first_o = first_m;
  end

endmodule

`default_nettype wire

### rtl/core/two_button_debounce_autorepeat.sv
// Top level of the two-switch debounce and auto-repeat block.
// Uses tbdar_pkg, tbdar_lane (two copies) and tbdar_merge.
// Each accepted item is one millisecond tick carrying both switch levels and
// yields exactly one result item with the two push events. Both lanes and the
// merge are combinational; the result lands in a one-entry output register,
// refilled in the same cycle it is taken, so one item per cycle is sustained
// while the output does not stall. Settle and repeat times are to be written
// through the configuration port while the block is idle; it does not check.
`default_nettype none

module two_button_debounce_autorepeat
  import tbdar_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               first_pressed_i,
  input  logic               second_pressed_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               first_event_o,
  output logic               second_event_o,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CountW-1:0]  cfg_data_i
);

  logic [CountW-1:0] settle_q;
  logic [CountW-1:0] repeat_q;
  sw_state_t         first_q;
  sw_state_t         second_q;
  logic              out_valid_q;
  logic              first_ev_q;
  logic              second_ev_q;
  logic              accept;
  lane_res_t         first_step;
  lane_res_t         second_step;
  lane_res_t         first_d;
  lane_res_t         second_d;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  tbdar_lane u_lane_first (
    .cur_i          (first_q),
    .pressed_i      (first_pressed_i),
    .settle_ticks_i (settle_q),
    .repeat_ticks_i (repeat_q),
    .res_o          (first_step)
  );

  tbdar_lane u_lane_second (
    .cur_i          (second_q),
    .pressed_i      (second_pressed_i),
    .settle_ticks_i (settle_q),
    .repeat_ticks_i (repeat_q),
    .res_o          (second_step)
  );

  tbdar_merge u_merge (
    .first_i  (first_step),
    .second_i (second_step),
    .first_o  (first_d),
    .second_o (second_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      settle_q <= SETTLE_RESET;
      repeat_q <= REPEAT_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SETTLE: settle_q <= cfg_data_i;
        CFG_REPEAT: repeat_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q     <= '{phase: PH_RELEASED, count: '0};
      second_q    <= '{phase: PH_RELEASED, count: '0};
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        first_q     <= first_d.st;
        second_q    <= second_d.st;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      first_ev_q  <= first_d.event_hit;
      second_ev_q <= second_d.event_hit;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign first_event_o  = first_ev_q;
  assign second_event_o = second_ev_q;

endmodule

`default_nettype wire

### dv/two_button_debounce_autorepeat_tb.sv
// Self-checking testbench for two_button_debounce_autorepeat: random and directed switch
// ticks against a cycle-free software copy of both debounce machines, with random stalls.
// Depends on tbdar_pkg and the two_button_debounce_autorepeat RTL.
`timescale 1ns / 100ps

module two_button_debounce_autorepeat_tb;
  import tbdar_pkg::*;

  localparam int STALL_LIMIT = 2000;

  typedef struct packed {
    logic first;
    logic second;
  } sw_pair_t;

  // Bit pairs are {first, second}.
  localparam logic [1:0] DIRECTED [25] = '{
    2'b10, 2'b01, 2'b01, 2'b11, 2'b11, 2'b11, 2'b00, 2'b11, 2'b00, 2'b01,
    2'b10, 2'b10, 2'b00, 2'b00, 2'b00, 2'b11, 2'b11, 2'b11, 2'b00, 2'b00,
    2'b00, 2'b10, 2'b10, 2'b10, 2'b10
  };

  logic              clk_i;
  logic              rst_ni = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic              first_pressed = 1'b0;
  logic              second_pressed = 1'b0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic              first_event;
  logic              second_event;
  logic              cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx = CFG_SETTLE;
  logic [CountW-1:0] cfg_data = '0;

  logic [CountW-1:0] settle_ticks = SETTLE_RESET;
  logic [CountW-1:0] repeat_ticks = REPEAT_RESET;
  logic [PhaseW-1:0] sw_phase [2] = '{PH_RELEASED, PH_RELEASED};
  logic [CountW-1:0] sw_count [2] = '{16'd0, 16'd0};

  sw_pair_t ticks_to_send [$];
  sw_pair_t pushes_due [$];

  int ticks_in = 0;
  int results_out = 0;
  int first_pushes = 0;
  int second_pushes = 0;
  int faults = 0;
  int stuck = 0;
  int settings_used = 1;

  two_button_debounce_autorepeat u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .first_pressed_i  (first_pressed),
    .second_pressed_i (second_pressed),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .first_event_o    (first_event),
    .second_event_o   (second_event),
    .cfg_we_i         (cfg_we),
    .cfg_idx_i        (cfg_idx),
    .cfg_data_i       (cfg_data)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic want_gap();
    if (ticks_in >= 500 && ticks_in < 800) begin
      return 1'b0;
    end
    return $urandom_range(99) < 11;
  endfunction

  function automatic logic tick_switch(input int k, input logic pressed);
    logic hit;
    hit = 1'b0;
    case (sw_phase[k])
      PH_RELEASED: begin
        if (pressed) begin
          sw_phase[k] = PH_SETTLE_ON;
          sw_count[k] = settle_ticks;
        end
      end
      PH_SETTLE_ON: begin
        sw_count[k] = sw_count[k] - 16'd1;
        if (sw_count[k] == 16'd0) begin
          hit = 1'b1;
          sw_phase[k] = PH_HELD;
          sw_count[k] = repeat_ticks;
        end
      end
      PH_HELD: begin
        if (!pressed) begin
          sw_phase[k] = PH_SETTLE_OFF;
          sw_count[k] = settle_ticks;
        end else begin
          sw_count[k] = sw_count[k] - 16'd1;
          if (sw_count[k] == 16'd0) begin
            hit = 1'b1;
            sw_count[k] = repeat_ticks;
          end
        end
      end
      default: begin
        sw_count[k] = sw_count[k] - 16'd1;
        if (sw_count[k] == 16'd0) begin
          sw_phase[k] = PH_RELEASED;
        end
      end
    endcase
    return hit;
  endfunction

  function automatic sw_pair_t debounce_tick(input sw_pair_t lvl);
    sw_pair_t ev;
    ev.first = tick_switch(0, lvl.first);
    ev.second = tick_switch(1, lvl.second);
    // A switch still settling its press joins the other switch when that one fires.
    if (sw_phase[0] == PH_SETTLE_ON && ev.second) begin
      ev.first = 1'b1;
      sw_phase[0] = sw_phase[1];
      sw_count[0] = sw_count[1];
    end
    if (sw_phase[1] == PH_SETTLE_ON && ev.first) begin
      ev.second = 1'b1;
      sw_phase[1] = sw_phase[0];
      sw_count[1] = sw_count[0];
    end
    return ev;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : drive
    sw_pair_t nxt;
    if (!rst_ni) begin
      in_valid <= 1'b0;
      first_pressed <= 1'b0;
      second_pressed <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (ticks_to_send.size() != 0 && !want_gap()) begin
        nxt = ticks_to_send.pop_front();
        in_valid <= 1'b1;
        first_pressed <= nxt.first;
        second_pressed <= nxt.second;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= want_gap();
    end
  end

  always @(posedge clk_i) begin : check
    sw_pair_t got;
    sw_pair_t want;
    logic moved;
    moved = 1'b0;
    if (rst_ni) begin
      if (in_valid && !in_stall) begin
        got.first = first_pressed;
        got.second = second_pressed;
        pushes_due.push_back(debounce_tick(got));
        ticks_in++;
        moved = 1'b1;
      end
      if (out_valid && !out_stall) begin
        got.first = first_event;
        got.second = second_event;
        results_out++;
        moved = 1'b1;
        if (got.first === 1'b1) first_pushes++;
        if (got.second === 1'b1) second_pushes++;
        if (pushes_due.size() == 0) begin
          faults++;
          if (faults <= 10) begin
            $display("result with nothing expected: first=%0b second=%0b",
                     got.first, got.second);
          end
        end else begin
          want = pushes_due.pop_front();
          if (got.first !== want.first || got.second !== want.second) begin
            faults++;
            if (faults <= 10) begin
              $display("result %0d: expected first=%0b second=%0b, got first=%0b second=%0b",
                       results_out, want.first, want.second, got.first, got.second);
            end
          end
        end
      end
      stuck = moved ? 0 : stuck + 1;
    end
  end

  initial begin : watchdog
    while (stuck < STALL_LIMIT) @(posedge clk_i);
    $display("two_button_debounce_autorepeat verification failed");
    $finish;
  end

  task automatic drain();
    while (ticks_to_send.size() != 0 || in_valid || pushes_due.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CountW-1:0] val);
    @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    if (idx == CFG_SETTLE) begin
      settle_ticks = val;
    end else begin
      repeat_ticks = val;
    end
  endtask

  task automatic retune(input logic [CountW-1:0] settle, input logic [CountW-1:0] rep);
    drain();
    write_reg(CFG_SETTLE, settle);
    write_reg(CFG_REPEAT, rep);
    settings_used++;
  endtask

  // Each switch alternates runs of pressed and released ticks, with a little noise on top.
  task automatic queue_presses(input int n);
    int left [2];
    logic lvl [2];
    int s;
    int r;
    int span;
    sw_pair_t t;
    left = '{0, 0};
    lvl = '{1'b0, 1'b0};
    s = (settle_ticks == 16'd0) ? 65536 : int'(settle_ticks);
    r = (repeat_ticks == 16'd0) ? 65536 : int'(repeat_ticks);
    span = 2 * s + 3 * r + 2;
    if (span > 400) span = 400;
    for (int i = 0; i < n; i++) begin
      for (int k = 0; k < 2; k++) begin
        if (left[k] == 0) begin
          if ($urandom_range(99) < 85) lvl[k] = !lvl[k];
          left[k] = $urandom_range(span, 1);
        end
        left[k]--;
      end
      if ($urandom_range(99) < 8) begin
        t = sw_pair_t'($urandom_range(3));
      end else begin
        t.first = lvl[0];
        t.second = lvl[1];
      end
      ticks_to_send.push_back(t);
    end
  endtask

  initial begin : stimulus
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    queue_presses(250);
    retune(16'd2, 16'd3);
    for (int i = 0; i < 25; i++) begin
      ticks_to_send.push_back(sw_pair_t'(DIRECTED[i]));
    end
    retune(16'd1, 16'd1);
    queue_presses(200);
    retune(16'd3, 16'd5);
    queue_presses(250);
    retune(16'd5, 16'd2);
    queue_presses(200);
    retune(16'd2, 16'd9);
    queue_presses(200);
    retune(16'd1, 16'd0);
    queue_presses(40);
    retune(16'd0, 16'd0);
    queue_presses(20);
    retune(16'hFFFF, 16'hFFFF);
    queue_presses(30);
    drain();
    repeat (4) @(posedge clk_i);
    $display("Ran %0d ticks under %0d register settings; %0d results checked.",
             ticks_in, settings_used, results_out);
    $display("Push events seen: %0d on the first switch, %0d on the second; %0d faults.",
             first_pushes, second_pushes, faults);
    if (faults == 0 && pushes_due.size() == 0) begin
      $display("two_button_debounce_autorepeat verification clean");
    end else begin
      $display("two_button_debounce_autorepeat verification failed");
    end
    $finish;
  end

endmodule
